>>> rtl/ndcm_pkg.sv
// Package: shared constants, command and status types for the coordinate merge block
`timescale 1ns / 1ps
`default_nettype none
package ndcm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int COORD_W     = 32;
  localparam int USE_W       = 16;
  localparam int SUM_W       = 22;
  localparam int TOL_W       = 16;
  localparam int ENTRY_W     = 6;
  localparam int ALIAS_W     = 7;
  localparam int TALLY_W     = 6;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 48;

  localparam logic [ALIAS_W-1:0] NO_ALIAS    = 7'd64;
  localparam logic [TOL_W-1:0]   TOL_DEFAULT = 16'd66;

  // controller -> datapath
  typedef struct packed {
    logic load;       // input request accepted this cycle
    logic rd_use_j;   // RAM read address: inner index instead of outer
    logic i_clr;
    logic i_inc;
    logic j_init;     // j = i + 1
    logic j_inc;
    logic outer_ld;   // capture outer coordinate and count from RAM data
    logic wb_outer;   // write outer count back
    logic absorb_j;   // outer absorbs inner
    logic absorb_i;   // inner absorbs outer
    logic tally_clr;
    logic emit_ld;    // load output register
    logic emit_done;  // clear table after last result
  } ndcm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic i_end;
    logic i_kept;
    logic i_last;
    logic j_end;
    logic j_kept;
    logic near;
    logic outer_gt;
    logic out_free;
  } ndcm_stat_t;

endpackage
`default_nettype wire

>>> rtl/ndcm_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module ndcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/ndcm_ctrl.sv
// Controller: sequences loading, the pairwise merge pass and result emission
`timescale 1ns / 1ps
`default_nettype none
module ndcm_ctrl
  import ndcm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tlast,
  output logic            in_tready,
  input  wire ndcm_stat_t stat,
  output ndcm_cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_OUT_SEL = 7'b0000010,
    S_OUT_LD  = 7'b0000100,
    S_IN_SEL  = 7'b0001000,
    S_IN_CMP  = 7'b0010000,
    S_EM_RD   = 7'b0100000,
    S_EM_LD   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.i_clr     = 1'b1;
            cmd.tally_clr = 1'b1;
            state_nxt     = S_OUT_SEL;
          end
        end
      end
      S_OUT_SEL: begin
        if (stat.i_end) begin
          cmd.i_clr = 1'b1;
          state_nxt = S_EM_RD;
        end else if (!stat.i_kept) begin
          cmd.i_inc = 1'b1;
        end else begin
          state_nxt = S_OUT_LD;
        end
      end
      S_OUT_LD: begin
        cmd.outer_ld = 1'b1;
        cmd.j_init   = 1'b1;
        state_nxt    = S_IN_SEL;
      end
      S_IN_SEL: begin
        cmd.rd_use_j = 1'b1;
        if (stat.j_end) begin
          cmd.wb_outer = 1'b1;
          cmd.i_inc    = 1'b1;
          state_nxt    = S_OUT_SEL;
        end else if (!stat.j_kept) begin
          cmd.j_inc = 1'b1;
        end else begin
          state_nxt = S_IN_CMP;
        end
      end
      S_IN_CMP: begin
        if (stat.near && stat.outer_gt) begin
          cmd.absorb_j = 1'b1;
          cmd.j_inc    = 1'b1;
          state_nxt    = S_IN_SEL;
        end else if (stat.near) begin
          // outer entry is gone, its scan ends here
          cmd.absorb_i = 1'b1;
          cmd.i_inc    = 1'b1;
          state_nxt    = S_OUT_SEL;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_IN_SEL;
        end
      end
      S_EM_RD: begin
        if (stat.out_free) begin
          state_nxt = S_EM_LD;
        end
      end
      S_EM_LD: begin
        cmd.emit_ld = 1'b1;
        if (stat.i_last) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_LOAD;
        end else begin
          cmd.i_inc = 1'b1;
          state_nxt = S_EM_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ndcm_dp.sv
// Datapath: entry tables, scan counters, tolerance compare and result register
`timescale 1ns / 1ps
`default_nettype none
module ndcm_dp
  import ndcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TOL_W-1:0]      cfg_wr_data,
  input  wire ndcm_cmd_t             cmd,
  output ndcm_stat_t                 stat,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  localparam logic [CNT_W-1:0] MAX_FILL = CNT_W'(MAX_ENTRIES);

  logic [TOL_W-1:0]       tol_r;
  logic [CNT_W-1:0]       fill_r;
  logic [CNT_W-1:0]       i_r;
  logic [CNT_W-1:0]       j_r;
  logic [TALLY_W-1:0]     tally_r;
  logic [MAX_ENTRIES-1:0] kept_r;
  logic [COORD_W-1:0]     outer_u_r;
  logic [COORD_W-1:0]     outer_v_r;
  logic [SUM_W-1:0]       outer_cnt_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_last_r;

  logic                   store;
  logic [IDX_W-1:0]       i_idx, j_idx, fill_idx, rd_addr;
  logic [2*COORD_W-1:0]   coord_rdata;
  logic [SUM_W-1:0]       cnt_rdata;
  logic [ALIAS_W-1:0]     alias_rdata;
  logic                   cnt_we, alias_we;
  logic [IDX_W-1:0]       cnt_waddr, alias_waddr;
  logic [SUM_W-1:0]       cnt_wdata;
  logic [ALIAS_W-1:0]     alias_wdata;
  logic [SUM_W-1:0]       cnt_sum;
  logic signed [COORD_W:0] du, dv, tol_s;
  logic [ALIAS_W-1:0]     em_alias;

  assign store    = cmd.load && (fill_r < MAX_FILL);
  assign i_idx    = i_r[IDX_W-1:0];
  assign j_idx    = j_r[IDX_W-1:0];
  assign fill_idx = fill_r[IDX_W-1:0];
  assign rd_addr  = cmd.rd_use_j ? j_idx : i_idx;

  // u in the upper half, v in the lower half
  ndcm_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_ENTRIES)) u_coord_ram (
    .clk   (clk),
    .we    (store),
    .waddr (fill_idx),
    .wdata ({in_tdata[COORD_W-1:0], in_tdata[2*COORD_W-1:COORD_W]}),
    .raddr (rd_addr),
    .rdata (coord_rdata)
  );

  ndcm_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ENTRIES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rdata)
  );

  ndcm_ram #(.WIDTH(ALIAS_W), .DEPTH(MAX_ENTRIES)) u_alias_ram (
    .clk   (clk),
    .we    (alias_we),
    .waddr (alias_waddr),
    .wdata (alias_wdata),
    .raddr (rd_addr),
    .rdata (alias_rdata)
  );

  assign cnt_sum = outer_cnt_r + cnt_rdata;

  always_comb begin
    cnt_we    = store || cmd.wb_outer || cmd.absorb_i || cmd.absorb_j;
    cnt_waddr = fill_idx;
    cnt_wdata = SUM_W'(in_tdata[2*COORD_W +: USE_W]);
    if (cmd.wb_outer) begin
      cnt_waddr = i_idx;
      cnt_wdata = outer_cnt_r;
    end else if (cmd.absorb_i) begin
      cnt_waddr = j_idx;
      cnt_wdata = cnt_sum;
    end else if (cmd.absorb_j) begin
      // outer count stays current in the table in case the outer entry is dropped later
      cnt_waddr = i_idx;
      cnt_wdata = cnt_sum;
    end
  end

  always_comb begin
    alias_we    = cmd.absorb_i || cmd.absorb_j;
    alias_waddr = j_idx;
    alias_wdata = ALIAS_W'(i_r);
    if (cmd.absorb_i) begin
      alias_waddr = i_idx;
      alias_wdata = ALIAS_W'(j_r);
    end
  end

  // |d| < tol as -tol < d < tol on exact 33-bit differences
  assign du    = $signed({outer_u_r[COORD_W-1], outer_u_r})
               - $signed({coord_rdata[2*COORD_W-1], coord_rdata[2*COORD_W-1:COORD_W]});
  assign dv    = $signed({outer_v_r[COORD_W-1], outer_v_r})
               - $signed({coord_rdata[COORD_W-1], coord_rdata[COORD_W-1:0]});
  assign tol_s = $signed({{(COORD_W+1-TOL_W){1'b0}}, tol_r});

  always_comb begin
    stat          = '0;
    stat.i_end    = (i_r == fill_r);
    stat.i_kept   = kept_r[i_idx];
    stat.i_last   = ((i_r + CNT_W'(1)) == fill_r);
    stat.j_end    = (j_r == fill_r);
    stat.j_kept   = kept_r[j_idx];
    stat.near     = (du < tol_s) && (du > -tol_s) && (dv < tol_s) && (dv > -tol_s);
    stat.outer_gt = (outer_cnt_r > cnt_rdata);
    stat.out_free = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_DEFAULT;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
      tally_r <= '0;
      kept_r  <= '0;
    end else begin
      if (store) begin
        fill_r           <= fill_r + CNT_W'(1);
        kept_r[fill_idx] <= 1'b1;
      end
      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + CNT_W'(1);
      end
      if (cmd.j_init) begin
        j_r <= i_r + CNT_W'(1);
      end else if (cmd.j_inc) begin
        j_r <= j_r + CNT_W'(1);
      end
      if (cmd.tally_clr) begin
        tally_r <= '0;
      end else if (cmd.absorb_i || cmd.absorb_j) begin
        tally_r <= tally_r + TALLY_W'(1);
      end
      if (cmd.absorb_j) begin
        kept_r[j_idx] <= 1'b0;
      end
      if (cmd.absorb_i) begin
        kept_r[i_idx] <= 1'b0;
      end
      if (cmd.emit_done) begin
        kept_r <= '0;
        fill_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.outer_ld) begin
      outer_u_r   <= coord_rdata[2*COORD_W-1:COORD_W];
      outer_v_r   <= coord_rdata[COORD_W-1:0];
      outer_cnt_r <= cnt_rdata;
    end else if (cmd.absorb_j) begin
      outer_cnt_r <= cnt_sum;
    end
  end

  assign em_alias = kept_r[i_idx] ? NO_ALIAS : alias_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ld) begin
      out_data_r <= {{(OUT_DATA_W-ENTRY_W-1-ALIAS_W-SUM_W-TALLY_W){1'b0}},
                     tally_r, cnt_rdata, em_alias, kept_r[i_idx], ENTRY_W'(i_r)};
      out_last_r <= stat.i_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ld |-> !out_valid_r)
    else $error("result register overwritten while still pending");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_FILL)
    else $error("fill level beyond table size");

  a_merge_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.absorb_i || cmd.absorb_j) |-> (stat.near && kept_r[i_idx] && kept_r[j_idx]))
    else $error("merge without a near duplicate between two kept entries");

  a_table_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_done |=> (kept_r == '0 && fill_r == '0))
    else $error("table not emptied after last result");

endmodule
`default_nettype wire

>>> rtl/near_duplicate_coord_merge.sv
// Input: items are taken while loading; results follow the item marked last.
// Merge pass: each kept outer entry is compared with the later kept entries in turn,
// paced by the single read port of the coordinate and count RAMs.
// Emission: one result per entry, loaded into the output register once it is free.
// Reset (rst_n, synchronous): table empty, tolerance 66; RAM contents undefined.
`timescale 1ns / 1ps
`default_nettype none
module near_duplicate_coord_merge
  import ndcm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // coord_u [31:0], coord_v [63:32], use_count [79:64]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // entry_index [5:0], entry_kept [6], alias_index [13:7], merged_count [35:14],
  // merges_total [41:36], zero [47:42]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [TOL_W-1:0]      cfg_wr_data
);

  ndcm_cmd_t  cmd;
  ndcm_stat_t stat;

  ndcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ndcm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire
